>>> rtl/wam_pkg.sv
// Shared types and constants for the wildcard alternation matcher.
// No dependencies; used by every module of the block but wam_ram.
package wam_pkg;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_BAR  = 8'h7C;
  localparam logic [7:0] CH_ESC  = 8'h5C;

  typedef enum logic [1:0] {
    CMD_PAT_BYTE = 2'd0,
    CMD_PAT_END  = 2'd1,
    CMD_TXT_BYTE = 2'd2,
    CMD_TXT_END  = 2'd3
  } cmd_code_t;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_ALT    = 11'b000_0000_0010,
    S_SCAN_W = 11'b000_0000_0100,
    S_SCAN_E = 11'b000_0000_1000,
    S_M_W    = 11'b000_0001_0000,
    S_M_E    = 11'b000_0010_0000,
    S_E_W    = 11'b000_0100_0000,
    S_E_E    = 11'b000_1000_0000,
    S_ST_W   = 11'b001_0000_0000,
    S_ST_E   = 11'b010_0000_0000,
    S_RES    = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    logic pat_byte;
    logic pat_end;
    logic txt_byte;
    logic txt_end;
    logic txt_clear;
    logic scan_sel;
    logic first_alt;
    logic scan_init;
    logic scan_adv;
    logic match_init;
    logic ip_inc;
    logic it_inc;
    logic mark;
    logic backtrack;
    logic next_alt;
  } dp_cmd_t;

  typedef struct packed {
    logic ovf;
    logic ip_lt_end;
    logic it_lt_tc;
    logic ip_eq_end;
    logic it_eq_tc;
    logic end_lt_pc;
    logic p_esc;
    logic p_star;
    logic p_bar;
    logic p_eq_t;
    logic scan_esc;
    logic seen;
  } dp_stat_t;

endpackage

>>> rtl/wam_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module wam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/wam_dp.sv
// Datapath: pattern and text stores, counts, and the match walk pointers.
// Depends on wam_pkg and wam_ram; driven by wam_ctrl commands.
module wam_dp #(
  parameter int PD = 64,
  parameter int TD = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  wam_pkg::dp_cmd_t  cmd,
  input  logic [7:0]        data_byte,
  output wam_pkg::dp_stat_t st
);
  import wam_pkg::*;

  localparam int PCW = $clog2(PD + 1);
  localparam int PAW = $clog2(PD);
  localparam int TCW = $clog2(TD + 1);
  localparam int TAW = $clog2(TD);

  logic [PCW-1:0] pc_r, pc_nxt, start_r, start_nxt, end_r, end_nxt;
  logic [PCW-1:0] ip_r, ip_nxt, spm_r, spm_nxt, p_eff;
  logic [TCW-1:0] tc_r, tc_nxt, it_r, it_nxt, stm_r, stm_nxt;
  logic filling_r, filling_nxt, ptl_r, ptl_nxt, ttl_r, ttl_nxt;
  logic esc_r, esc_nxt, seen_r, seen_nxt;
  logic p_we, t_we;
  logic [7:0] p_q, t_q;
  logic [PCW-1:0] p_raddr;

  assign p_eff   = filling_r ? pc_r : '0;
  assign p_we    = cmd.pat_byte && (p_eff < PCW'(PD));
  assign t_we    = cmd.txt_byte && (tc_r < TCW'(TD));
  assign p_raddr = cmd.scan_sel ? end_r : ip_r;

  wam_ram #(.WIDTH(8), .DEPTH(PD)) u_pat (
    .clk(clk), .we(p_we), .waddr(p_eff[PAW-1:0]), .wdata(data_byte),
    .raddr(p_raddr[PAW-1:0]), .rdata(p_q));

  wam_ram #(.WIDTH(8), .DEPTH(TD)) u_txt (
    .clk(clk), .we(t_we), .waddr(tc_r[TAW-1:0]), .wdata(data_byte),
    .raddr(it_r[TAW-1:0]), .rdata(t_q));

  always_comb begin
    pc_nxt = pc_r; filling_nxt = filling_r; ptl_nxt = ptl_r;
    tc_nxt = tc_r; ttl_nxt = ttl_r;
    start_nxt = start_r; end_nxt = end_r; esc_nxt = esc_r;
    ip_nxt = ip_r; it_nxt = it_r; spm_nxt = spm_r; stm_nxt = stm_r;
    seen_nxt = seen_r;
    if (cmd.pat_byte) begin
      filling_nxt = 1'b1;
      if (!filling_r) ptl_nxt = 1'b0;
      if (p_we) pc_nxt = p_eff + 1'b1;
      else ptl_nxt = 1'b1;
    end
    if (cmd.pat_end) begin
      if (!filling_r) begin
        pc_nxt = '0;
        ptl_nxt = 1'b0;
      end
      filling_nxt = 1'b0;
    end
    if (cmd.txt_byte) begin
      filling_nxt = 1'b0;
      if (t_we) tc_nxt = tc_r + 1'b1;
      else ttl_nxt = 1'b1;
    end
    if (cmd.txt_end) filling_nxt = 1'b0;
    if (cmd.txt_clear) begin
      tc_nxt = '0;
      ttl_nxt = 1'b0;
    end
    if (cmd.first_alt) start_nxt = '0;
    if (cmd.scan_init) begin
      end_nxt = start_r;
      esc_nxt = 1'b0;
    end
    if (cmd.scan_adv) begin
      esc_nxt = (p_q == CH_ESC) ? !esc_r : 1'b0;
      end_nxt = end_r + 1'b1;
    end
    if (cmd.match_init) begin
      ip_nxt = start_r; it_nxt = '0; spm_nxt = '0; stm_nxt = '0;
      seen_nxt = 1'b0;
    end
    if (cmd.ip_inc) ip_nxt = ip_r + 1'b1;
    if (cmd.it_inc) it_nxt = it_r + 1'b1;
    if (cmd.mark) begin
      spm_nxt = ip_r; stm_nxt = it_r; seen_nxt = 1'b1;
    end
    if (cmd.backtrack) begin
      stm_nxt = stm_r + 1'b1;
      ip_nxt = spm_r;
      it_nxt = stm_r + 1'b1;
    end
    if (cmd.next_alt) start_nxt = end_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0; filling_r <= 1'b0; ptl_r <= 1'b0;
      tc_r <= '0; ttl_r <= 1'b0; seen_r <= 1'b0;
      spm_r <= '0; stm_r <= '0;
    end else begin
      pc_r <= pc_nxt; filling_r <= filling_nxt; ptl_r <= ptl_nxt;
      tc_r <= tc_nxt; ttl_r <= ttl_nxt; seen_r <= seen_nxt;
      spm_r <= spm_nxt; stm_r <= stm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt; end_r <= end_nxt; esc_r <= esc_nxt;
    ip_r <= ip_nxt; it_r <= it_nxt;
  end

  always_comb begin
    st.ovf       = ptl_r || ttl_r;
    st.ip_lt_end = ip_r < end_r;
    st.it_lt_tc  = it_r < tc_r;
    st.ip_eq_end = ip_r == end_r;
    st.it_eq_tc  = it_r == tc_r;
    st.end_lt_pc = end_r < pc_r;
    st.p_esc     = p_q == CH_ESC;
    st.p_star    = p_q == CH_STAR;
    st.p_bar     = p_q == CH_BAR;
    st.p_eq_t    = p_q == t_q;
    st.scan_esc  = esc_r;
    st.seen      = seen_r;
  end
endmodule

>>> rtl/wam_ctrl.sv
// Controller: accepts items, sequences the match walk, holds the result.
// Depends on wam_pkg; drives wam_dp through command and status structs.
module wam_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        in_cmd,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic              res_matched,
  output logic              res_overflow,
  output wam_pkg::dp_cmd_t  cmd,
  input  wam_pkg::dp_stat_t st
);
  import wam_pkg::*;

  state_t state_r, state_nxt;
  logic hit_r, hit_nxt, ovf_r, ovf_nxt;
  logic ov_r, ov_nxt, om_r, om_nxt, oo_r, oo_nxt;
  logic accept, do_cmp;

  assign in_tready    = state_r == S_IDLE;
  assign accept       = in_tvalid && in_tready;
  assign out_tvalid   = ov_r;
  assign res_matched  = om_r;
  assign res_overflow = oo_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    hit_nxt = hit_r; ovf_nxt = ovf_r;
    ov_nxt = ov_r && !out_tready; om_nxt = om_r; oo_nxt = oo_r;
    do_cmp = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (cmd_code_t'(in_cmd))
            CMD_PAT_BYTE: cmd.pat_byte = 1'b1;
            CMD_PAT_END:  cmd.pat_end = 1'b1;
            CMD_TXT_BYTE: cmd.txt_byte = 1'b1;
            CMD_TXT_END: begin
              cmd.txt_end = 1'b1;
              ovf_nxt = st.ovf;
              hit_nxt = 1'b0;
              if (st.ovf) begin
                state_nxt = S_RES;
              end else begin
                cmd.first_alt = 1'b1;
                state_nxt = S_ALT;
              end
            end
            default: ;
          endcase
        end
      end
      S_ALT: begin
        cmd.scan_init = 1'b1;
        state_nxt = S_SCAN_W;
      end
      S_SCAN_W: begin
        cmd.scan_sel = 1'b1;
        state_nxt = S_SCAN_E;
      end
      S_SCAN_E: begin
        cmd.scan_sel = 1'b1;
        if (st.end_lt_pc && (!st.p_bar || st.scan_esc)) begin
          cmd.scan_adv = 1'b1;
          state_nxt = S_SCAN_W;
        end else begin
          cmd.match_init = 1'b1;
          state_nxt = S_M_W;
        end
      end
      S_M_W: state_nxt = S_M_E;
      S_M_E: begin
        if (st.ip_eq_end && st.it_eq_tc) begin
          hit_nxt = 1'b1;
          state_nxt = S_RES;
        end else if (st.ip_lt_end && st.p_esc) begin
          cmd.ip_inc = 1'b1;
          state_nxt = S_E_W;
        end else if (st.ip_lt_end && st.p_star) begin
          cmd.ip_inc = 1'b1;
          state_nxt = S_ST_W;
        end else begin
          do_cmp = 1'b1;
        end
      end
      S_E_W: state_nxt = S_E_E;
      S_E_E: do_cmp = 1'b1;
      S_ST_W: state_nxt = S_ST_E;
      S_ST_E: begin
        if (st.ip_lt_end && st.p_star) begin
          cmd.ip_inc = 1'b1;
          state_nxt = S_ST_W;
        end else begin
          cmd.mark = 1'b1;
          state_nxt = S_M_W;
        end
      end
      S_RES: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          om_nxt = hit_r;
          oo_nxt = ovf_r;
          cmd.txt_clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // literal compare, else backtrack to the last star, else try next alternative or post the result if none is left
    if (do_cmp) begin
      if (st.ip_lt_end && st.it_lt_tc && st.p_eq_t) begin
        cmd.ip_inc = 1'b1;
        cmd.it_inc = 1'b1;
        state_nxt = S_M_W;
      end else if (st.seen && st.it_lt_tc) begin
        cmd.backtrack = 1'b1;
        state_nxt = S_M_W;
      end else if (!st.end_lt_pc) begin
        state_nxt = S_RES;
      end else begin
        cmd.next_alt = 1'b1;
        state_nxt = S_ALT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt; ovf_r <= ovf_nxt; om_r <= om_nxt; oo_r <= oo_nxt;
  end
endmodule

>>> rtl/wildcard_alternation_matcher_top.sv
// Top level of the wildcard alternation matcher: stream ports, controller
// and datapath. Depends on wam_pkg, wam_ctrl, wam_dp (and wam_ram below it).
//
//  channel   | dir | ports                              | contents
//  ----------+-----+------------------------------------+-------------------------
//  in_       | in  | in_tvalid/in_tready/in_tdata/tuser | one pattern/text command
//  out_      | out | out_tvalid/out_tready/out_tdata    | one match result
//
// Text end runs the match walk. Every evaluation has a wait state for the
// registered store read and a state to decide. An evaluation is a scanned
// pattern position, including the end of the alternative, or a walk step,
// including the last check. Each tried alternative adds a setup state, and
// posting the result adds the result state. The registered read port of each
// store RAM calls for the wait state. With overflow set the match walk is
// skipped and the block goes straight to the result state, which posts the
// result once the result slot is free. Synchronous active-low reset empties
// both stores by clearing their counts; store contents are not cleared. Items
// are taken while a result waits; a match whose result slot is still full
// holds until out_tready frees it.
module wildcard_alternation_matcher_top #(
  parameter int PATTERN_DEPTH = 64,
  parameter int TEXT_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [1:0] in_tuser,   // [1:0] command
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] matched, [1] overflow, [7:2] zero
);
  import wam_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;
  logic     res_matched, res_overflow;

  // controller: handshake, sequencing and result register
  wam_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_cmd(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .res_matched(res_matched), .res_overflow(res_overflow),
    .cmd(cmd), .st(st));

  // datapath: stores, counts, walk pointers and compares
  wam_dp #(.PD(PATTERN_DEPTH), .TD(TEXT_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .data_byte(in_tdata), .st(st));

  assign out_tdata = {6'd0, res_overflow, res_matched};

  // overflow always forces no match
  a_ovf_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("match reported together with overflow");

  // a text end item always takes the block busy
  a_txt_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == CMD_TXT_END) |=> !in_tready)
    else $error("block idle right after text end");

  // a new result only comes from the busy phase
  a_res_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result raised without a match phase");
endmodule
